// ----- sv/dcy_pkg.sv -----
`default_nettype none

package dcy_pkg;

   localparam int FRAME_WIDTH  = 224;
   localparam int FRAME_HEIGHT = 172;

   localparam int DEPTH_W = 16;
   localparam int COORD_W = 9;
   localparam int STEP_W  = 13;
   localparam int SUM_W   = 32;
   localparam int CNT_W   = 17;
   localparam int AVG_W   = 15;
   localparam int QIDX_W  = 4;
   localparam int COEF_W  = 17;
   localparam int ACC_W   = 26;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_STEP  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROI_TOP    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROI_BOTTOM = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROI_LEFT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROI_RIGHT  = 3'd4;

   // top quotient bit for each use of the divider
   localparam logic [QIDX_W-1:0] RAMP_TOP_BIT = 4'd7;
   localparam logic [QIDX_W-1:0] AVG_TOP_BIT  = 4'd14;

   // colour conversion coefficients, scaled by 65536
   localparam logic signed [COEF_W-1:0] COEF_YR = 17'sd16842;
   localparam logic signed [COEF_W-1:0] COEF_YG = 17'sd33030;
   localparam logic signed [COEF_W-1:0] COEF_YB = 17'sd6422;
   localparam logic signed [COEF_W-1:0] COEF_UR = -17'sd9699;
   localparam logic signed [COEF_W-1:0] COEF_UG = -17'sd19070;
   localparam logic signed [COEF_W-1:0] COEF_UB = 17'sd28770;
   localparam logic signed [COEF_W-1:0] COEF_VR = 17'sd28770;
   localparam logic signed [COEF_W-1:0] COEF_VG = -17'sd24117;
   localparam logic signed [COEF_W-1:0] COEF_VB = -17'sd4653;

   localparam logic signed [ACC_W-1:0] Y_OFFSET = 26'sd1048576;
   localparam logic signed [ACC_W-1:0] C_OFFSET = 26'sd8388608;

   typedef struct packed {
      logic                start;
      logic [SUM_W-1:0]    dividend;
      logic [CNT_W-1:0]    divisor;
      logic [QIDX_W-1:0]   top_bit;
   } div_req_type;

   typedef struct packed {
      logic                busy;
      logic                done;
      logic [AVG_W-1:0]    quotient;
   } div_rsp_type;

   typedef struct packed {
      logic       start;
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      logic       odd;
   } yuv_req_type;

   typedef struct packed {
      logic       busy;
      logic       done;
      logic [7:0] y;
      logic [7:0] c;
   } yuv_rsp_type;

   // coefficient for one step of the multiply-accumulate sequence
   function automatic logic signed [COEF_W-1:0] yuv_coef(input logic [2:0] step,
                                                         input logic odd);
      logic signed [COEF_W-1:0] coef;
      case (step)
         3'd0:    coef = COEF_YR;
         3'd1:    coef = COEF_YG;
         3'd2:    coef = COEF_YB;
         3'd3:    coef = odd ? COEF_VR : COEF_UR;
         3'd4:    coef = odd ? COEF_VG : COEF_UG;
         3'd5:    coef = odd ? COEF_VB : COEF_UB;
         default: coef = '0;
      endcase
      return coef;
   endfunction

endpackage

`default_nettype wire

// ----- sv/dcy_if.sv -----
`default_nettype none

interface dcy_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [dcy_pkg::DEPTH_W-1:0]    depth_sample;

   modport source (output valid, output depth_sample, input ready);
   modport sink   (input valid, input depth_sample, output ready);
endinterface

interface dcy_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [7:0]                   luma;
   logic [7:0]                   chroma;
   logic                         chroma_is_v;
   logic                         frame_end;
   logic [dcy_pkg::AVG_W-1:0]    roi_average;

   modport source (output valid, output luma, output chroma, output chroma_is_v,
                   output frame_end, output roi_average, input ready);
   modport sink   (input valid, input luma, input chroma, input chroma_is_v,
                   input frame_end, input roi_average, output ready);
endinterface

interface dcy_csr_if;
   logic                              valid;
   logic                              ready;
   logic [dcy_pkg::CSR_IDX_W-1:0]     index;
   logic [dcy_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/dcy_div.sv -----
`default_nettype none

module dcy_div (
   input  wire                   clock,
   input  wire                   reset,
   input  dcy_pkg::div_req_type  div_req,
   output dcy_pkg::div_rsp_type  div_rsp
);

   logic [dcy_pkg::SUM_W-1:0]  rem_ff, rem_in;
   logic [dcy_pkg::SUM_W-1:0]  dsh_ff, dsh_in;
   logic [dcy_pkg::AVG_W-1:0]  quo_ff, quo_in;
   logic [dcy_pkg::QIDX_W-1:0] cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic                       ge;

   // one restoring compare-subtract per cycle, msb of the quotient first
   assign ge = (rem_ff >= dsh_ff);

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = div_req.dividend;
         dsh_in  = dcy_pkg::SUM_W'(div_req.divisor) << div_req.top_bit;
         quo_in  = '0;
         cnt_in  = div_req.top_bit;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (ge) begin
            rem_in = rem_ff - dsh_ff;
         end
         quo_in = {quo_ff[dcy_pkg::AVG_W-2:0], ge};
         dsh_in = dsh_ff >> 1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff)
      else $error("divider started while busy");

   a_last_step: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !div_req.start && cnt_ff == '0 |=> done_ff && !busy_ff)
      else $error("divider did not finish after its last step");

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while still busy");

endmodule

`default_nettype wire

// ----- sv/dcy_yuv.sv -----
`default_nettype none

module dcy_yuv (
   input  wire                   clock,
   input  wire                   reset,
   input  dcy_pkg::yuv_req_type  yuv_req,
   output dcy_pkg::yuv_rsp_type  yuv_rsp
);

   logic [2:0]                             step_ff, step_in;
   logic                                   busy_ff, busy_in;
   logic                                   done_ff, done_in;
   logic signed [dcy_pkg::ACC_W-1:0]       acc_ff, acc_in;
   logic [7:0]                             r_ff, g_ff, b_ff;
   logic                                   odd_ff;
   logic [7:0]                             y_ff, y_in;
   logic [7:0]                             c_ff, c_in;
   logic [7:0]                             x;
   logic signed [dcy_pkg::COEF_W-1:0]      coef;
   logic signed [dcy_pkg::ACC_W-1:0]       prod;
   logic signed [dcy_pkg::ACC_W-1:0]       sum;

   // steps 0..2 build Y from r, g, b, steps 3..5 build U or V
   always_comb begin
      case (step_ff)
         3'd0, 3'd3: x = r_ff;
         3'd1, 3'd4: x = g_ff;
         default:    x = b_ff;
      endcase
   end

   assign coef = dcy_pkg::yuv_coef(step_ff, odd_ff);
   assign prod = dcy_pkg::ACC_W'(coef) * dcy_pkg::ACC_W'($signed({1'b0, x}));
   assign sum  = acc_ff + prod;

   always_comb begin
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      acc_in  = acc_ff;
      y_in    = y_ff;
      c_in    = c_ff;
      if (yuv_req.start) begin
         step_in = '0;
         busy_in = 1'b1;
         acc_in  = dcy_pkg::Y_OFFSET;
      end else if (busy_ff) begin
         step_in = step_ff + 1'b1;
         if (step_ff == 3'd2) begin
            y_in   = sum[23:16];
            acc_in = dcy_pkg::C_OFFSET;
         end else if (step_ff == 3'd5) begin
            c_in    = sum[23:16];
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            acc_in = sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      acc_ff <= acc_in;
      y_ff   <= y_in;
      c_ff   <= c_in;
      if (yuv_req.start) begin
         r_ff   <= yuv_req.r;
         g_ff   <= yuv_req.g;
         b_ff   <= yuv_req.b;
         odd_ff <= yuv_req.odd;
      end
   end

   assign yuv_rsp.busy = busy_ff;
   assign yuv_rsp.done = done_ff;
   assign yuv_rsp.y    = y_ff;
   assign yuv_rsp.c    = c_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      yuv_req.start |-> !busy_ff)
      else $error("colour converter started while busy");

   a_finish: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !yuv_req.start && step_ff == 3'd5 |=> done_ff && !busy_ff)
      else $error("colour converter missed its last step");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> step_ff <= 3'd5)
      else $error("colour converter step out of range");

endmodule

`default_nettype wire

// ----- sv/depth_colormap_to_yuyv.sv -----
// Depth pixel to YUYV colour-map converter.
// req_ch takes one signed depth pixel per item, in raster order over a
// FRAME_WIDTH by FRAME_HEIGHT frame. rsp_ch returns one item per pixel: the
// Y byte and the U (even pixel) or V (odd pixel) byte of the colour-mapped
// depth, a frame end flag on the last pixel, and on that pixel the integer
// average of the positive depths inside the region of interest.
// csr_ch writes band_step and the four region bounds; it is always ready and
// is meant to be written only between items.
// Black, white and region pixels go from accept to result without the divider;
// pixels on the colour ramp also wait for the shared serial divider to work
// out the ramp fraction. The frame's last pixel, when the region counted any
// depth, also waits for the 15-bit average on the same divider. The YUV conversion
// is a single multiply-accumulate stepped through the Y and then the U or V
// products. req_ch is ready only while no item is in work, so a new item is
// taken only once the last one has handed its result to the output register.
// The result sits in an output register; a stalled receiver holds it there
// and the next item may be taken and worked on meanwhile, waiting only to
// hand its result over. Reset (synchronous) returns the counters, the sums
// and the output to empty and the registers to their reset values.
`default_nettype none

module depth_colormap_to_yuyv (
   input  wire        clock,
   input  wire        reset,
   dcy_req_if.sink    req_ch,
   dcy_rsp_if.source  rsp_ch,
   dcy_csr_if.sink    csr_ch
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_BAND = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_YST  = 3'd3;
   localparam logic [2:0] ST_YUV  = 3'd4;
   localparam logic [2:0] ST_AVG  = 3'd5;
   localparam logic [2:0] ST_OUT  = 3'd6;

   localparam logic [2:0] BAND_RED    = 3'd1;
   localparam logic [2:0] BAND_YELLOW = 3'd2;
   localparam logic [2:0] BAND_GREEN  = 3'd3;
   localparam logic [2:0] BAND_CYAN   = 3'd4;
   localparam logic [2:0] BAND_BLUE   = 3'd5;

   localparam int DW = dcy_pkg::DEPTH_W;
   localparam int CW = dcy_pkg::COORD_W;

   logic [2:0]                    state_ff, state_in;

   logic [dcy_pkg::STEP_W-1:0]    band_step_ff;
   logic [CW-1:0]                 roi_top_ff, roi_bottom_ff, roi_left_ff, roi_right_ff;

   logic [CW-1:0]                 col_ff, col_in;
   logic [CW-1:0]                 row_ff, row_in;
   logic                          parity_ff, parity_in;
   logic [dcy_pkg::SUM_W-1:0]     sum_ff, sum_in;
   logic [dcy_pkg::CNT_W-1:0]     samples_ff, samples_in;

   logic [DW-1:0]                 depth_ff;
   logic                          in_roi_ff, last_ff, odd_ff;
   logic [dcy_pkg::SUM_W-1:0]     avg_num_ff;
   logic [dcy_pkg::CNT_W-1:0]     avg_den_ff;

   logic [2:0]                    band_ff;
   logic [7:0]                    r_ff, g_ff, b_ff;
   logic [7:0]                    y_ff, c_ff;
   logic [dcy_pkg::AVG_W-1:0]     avg_ff;

   logic                          rsp_valid_ff;
   logic [7:0]                    rsp_luma_ff, rsp_chroma_ff;
   logic                          rsp_v_ff, rsp_end_ff;
   logic [dcy_pkg::AVG_W-1:0]     rsp_avg_ff;

   logic                          req_fire, out_free, out_load;
   logic                          in_roi, depth_pos, last, counted;
   logic [dcy_pkg::SUM_W-1:0]     sum_add;
   logic [dcy_pkg::CNT_W-1:0]     samples_add;

   logic [DW-1:0]                 d, s1, s2, s3, s4, s5, num16;
   logic                          item_pos, item_zero, need_div;
   logic [2:0]                    band_sel;
   logic [dcy_pkg::STEP_W-1:0]    num;
   logic [20:0]                   ramp_dividend;
   logic [7:0]                    q8;

   dcy_pkg::div_req_type          div_req;
   dcy_pkg::div_rsp_type          div_rsp;
   dcy_pkg::yuv_req_type          yuv_req;
   dcy_pkg::yuv_rsp_type          yuv_rsp;

   // configuration port
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         band_step_ff  <= dcy_pkg::STEP_W'(30);
         roi_top_ff    <= '0;
         roi_bottom_ff <= '0;
         roi_left_ff   <= '0;
         roi_right_ff  <= '0;
      end else if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            dcy_pkg::CSR_BAND_STEP:  band_step_ff  <= csr_ch.data;
            dcy_pkg::CSR_ROI_TOP:    roi_top_ff    <= csr_ch.data[CW-1:0];
            dcy_pkg::CSR_ROI_BOTTOM: roi_bottom_ff <= csr_ch.data[CW-1:0];
            dcy_pkg::CSR_ROI_LEFT:   roi_left_ff   <= csr_ch.data[CW-1:0];
            dcy_pkg::CSR_ROI_RIGHT:  roi_right_ff  <= csr_ch.data[CW-1:0];
            default: ;
         endcase
      end
   end

   // frame position and region statistics, updated as an item is taken
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign in_roi = (row_ff >= roi_top_ff) && (row_ff < roi_bottom_ff) &&
                   (col_ff >= roi_left_ff) && (col_ff < roi_right_ff);
   assign depth_pos = !req_ch.depth_sample[DW-1] && (req_ch.depth_sample != '0);
   assign counted   = in_roi && depth_pos;
   assign last = (col_ff >= CW'(dcy_pkg::FRAME_WIDTH - 1)) &&
                 (row_ff >= CW'(dcy_pkg::FRAME_HEIGHT - 1));
   assign sum_add     = sum_ff + {{(dcy_pkg::SUM_W-DW+1){1'b0}}, req_ch.depth_sample[DW-2:0]};
   assign samples_add = samples_ff + 1'b1;

   always_comb begin
      col_in     = col_ff;
      row_in     = row_ff;
      parity_in  = parity_ff;
      sum_in     = sum_ff;
      samples_in = samples_ff;
      if (req_fire) begin
         if (last) begin
            col_in     = '0;
            row_in     = '0;
            parity_in  = 1'b0;
            sum_in     = '0;
            samples_in = '0;
         end else begin
            parity_in = !parity_ff;
            if (col_ff >= CW'(dcy_pkg::FRAME_WIDTH - 1)) begin
               col_in = '0;
               row_in = row_ff + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
            if (counted) begin
               sum_in     = sum_add;
               samples_in = samples_add;
            end
         end
      end
   end

   // band of the ramp and the fraction numerator
   assign item_zero = (depth_ff == '0);
   assign item_pos  = !depth_ff[DW-1] && !item_zero;
   assign d  = {1'b0, depth_ff[DW-2:0]};
   assign s1 = DW'(band_step_ff);
   assign s2 = s1 << 1;
   assign s3 = s1 + s2;
   assign s4 = s1 << 2;
   assign s5 = s1 + s4;

   always_comb begin
      if (d <= s1) begin
         band_sel = BAND_RED;
         num16    = d;
      end else if (d <= s2) begin
         band_sel = BAND_YELLOW;
         num16    = d - s1;
      end else if (d <= s3) begin
         band_sel = BAND_GREEN;
         num16    = s3 - d;
      end else if (d <= s4) begin
         band_sel = BAND_CYAN;
         num16    = d - s3;
      end else begin
         band_sel = BAND_BLUE;
         num16    = s5 - d;
      end
   end

   assign num           = num16[dcy_pkg::STEP_W-1:0];
   assign ramp_dividend = {num, 8'b0} - 21'(num);
   assign need_div      = !in_roi_ff && item_pos && (band_step_ff != '0) && (d <= s5);
   assign q8            = div_rsp.quotient[7:0];

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_fire) state_in = ST_BAND;
         ST_BAND: state_in = need_div ? ST_DIV : ST_YST;
         ST_DIV:  if (div_rsp.done) state_in = ST_YST;
         ST_YST:  state_in = ST_YUV;
         ST_YUV: begin
            if (yuv_rsp.done) begin
               state_in = (last_ff && avg_den_ff != '0) ? ST_AVG : ST_OUT;
            end
         end
         ST_AVG:  if (div_rsp.done) state_in = ST_OUT;
         ST_OUT:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      div_req.start = ((state_ff == ST_BAND) && need_div) ||
                      ((state_ff == ST_YUV) && yuv_rsp.done && last_ff &&
                       (avg_den_ff != '0));
      if (state_ff == ST_BAND) begin
         div_req.dividend = dcy_pkg::SUM_W'(ramp_dividend);
         div_req.divisor  = dcy_pkg::CNT_W'(band_step_ff);
         div_req.top_bit  = dcy_pkg::RAMP_TOP_BIT;
      end else begin
         div_req.dividend = avg_num_ff;
         div_req.divisor  = avg_den_ff;
         div_req.top_bit  = dcy_pkg::AVG_TOP_BIT;
      end
   end

   assign yuv_req.start = (state_ff == ST_YST);
   assign yuv_req.r     = r_ff;
   assign yuv_req.g     = g_ff;
   assign yuv_req.b     = b_ff;
   assign yuv_req.odd   = odd_ff;

   dcy_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   dcy_yuv u_yuv (
      .clock   (clock),
      .reset   (reset),
      .yuv_req (yuv_req),
      .yuv_rsp (yuv_rsp)
   );

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign out_load = (state_ff == ST_OUT) && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         parity_ff    <= 1'b0;
         sum_ff       <= '0;
         samples_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         parity_ff  <= parity_in;
         sum_ff     <= sum_in;
         samples_ff <= samples_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      if (req_fire) begin
         depth_ff   <= req_ch.depth_sample;
         in_roi_ff  <= in_roi;
         last_ff    <= last;
         odd_ff     <= parity_ff;
         avg_num_ff <= counted ? sum_add : sum_ff;
         avg_den_ff <= counted ? samples_add : samples_ff;
      end

      if (state_ff == ST_BAND) begin
         band_ff <= band_sel;
         if (in_roi_ff || !item_zero) begin
            r_ff <= 8'hFF;
            g_ff <= 8'hFF;
            b_ff <= 8'hFF;
         end else begin
            r_ff <= 8'h00;
            g_ff <= 8'h00;
            b_ff <= 8'h00;
         end
      end

      if ((state_ff == ST_DIV) && div_rsp.done) begin
         case (band_ff)
            BAND_RED:    begin r_ff <= q8;    g_ff <= 8'h00; b_ff <= 8'h00; end
            BAND_YELLOW: begin r_ff <= 8'hFF; g_ff <= q8;    b_ff <= 8'h00; end
            BAND_GREEN:  begin r_ff <= q8;    g_ff <= 8'hFF; b_ff <= 8'h00; end
            BAND_CYAN:   begin r_ff <= 8'h00; g_ff <= 8'hFF; b_ff <= q8;    end
            default:     begin r_ff <= 8'h00; g_ff <= q8;    b_ff <= 8'hFF; end
         endcase
      end

      if ((state_ff == ST_YUV) && yuv_rsp.done) begin
         y_ff   <= yuv_rsp.y;
         c_ff   <= yuv_rsp.c;
         avg_ff <= '0;
      end
      if ((state_ff == ST_AVG) && div_rsp.done) begin
         avg_ff <= div_rsp.quotient;
      end

      if (out_load) begin
         rsp_luma_ff   <= y_ff;
         rsp_chroma_ff <= c_ff;
         rsp_v_ff      <= odd_ff;
         rsp_end_ff    <= last_ff;
         rsp_avg_ff    <= avg_ff;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.luma        = rsp_luma_ff;
   assign rsp_ch.chroma      = rsp_chroma_ff;
   assign rsp_ch.chroma_is_v = rsp_v_ff;
   assign rsp_ch.frame_end   = rsp_end_ff;
   assign rsp_ch.roi_average = rsp_avg_ff;

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_OUT) |-> !div_rsp.busy && !yuv_rsp.busy)
      else $error("arithmetic unit busy with no item in work");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      out_load && last_ff |-> col_ff == '0 && row_ff == '0 && !parity_ff)
      else $error("frame counters not restarted after the last pixel");

   a_avg_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_end_ff |-> rsp_avg_ff == '0)
      else $error("average reported on a pixel that does not end the frame");

endmodule

`default_nettype wire
